### rtl/kpc_pkg.sv
// Shared constants and register indexes for the key press and click decoder.
package kpc_pkg;

  localparam int LANE_LIMIT        = 32;
  localparam int CFG_W             = 16;
  localparam int CFG_INDEX_W       = 3;
  localparam int NUM_KEYS_DEF      = 32;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TIME      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LONG_TIME  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_GAP_TIME  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_HOLD_TIME = 3'd4;

  localparam logic [CFG_W-1:0] SHORT_TIME_RST      = 16'd5;
  localparam logic [CFG_W-1:0] LONG_TIME_RST       = 16'd100;
  localparam logic [CFG_W-1:0] LONG_LONG_TIME_RST  = 16'd300;
  localparam logic [CFG_W-1:0] CLICK_GAP_TIME_RST  = 16'd30;
  localparam logic [CFG_W-1:0] CLICK_HOLD_TIME_RST = 16'd10;

endpackage

### rtl/key_press_click_decoder.sv
// Key press and click decoder: per-key hold timers and click chain tracking.
//
// Usage:
//   Scan channel: one word per tick carries scan_bits, bit i set when key i is
//   down. Words are taken when scan_valid is high and scan_stall is low.
//   Result channel: one word per scan word with the held, short, long,
//   very-long and click masks after that tick, plus changed when any key
//   event flag moved. The word is taken when result_valid is high and
//   result_stall is low.
//   Config: cfg_we writes cfg_data to the register at cfg_index (0 short,
//   1 long, 2 very long, 3 click gap, 4 click hold); other indexes are
//   ignored. Write only while no word is in flight.
// Timing:
//   A scan word is held in the input register, then all key lanes update in
//   parallel and the result register loads the masks.
//   One word per cycle is sustained while result_stall is low; the lane
//   counter update and threshold compare is combinational between the two registers.
// Reset clears all key state, loads default thresholds and empties both
// registers. When result_stall holds the output, the input register still
// takes one more word, then scan_stall rises until the result is taken.
module key_press_click_decoder #(
  parameter int NUM_KEYS    = kpc_pkg::NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            scan_valid,
  output logic                            scan_stall,
  input  logic [kpc_pkg::LANE_LIMIT-1:0]  scan_bits,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  held_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  short_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  long_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  very_long_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  single_click_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  double_click_mask,
  output logic [kpc_pkg::LANE_LIMIT-1:0]  triple_click_mask,
  output logic                            changed,
  input  logic                            cfg_we,
  input  logic [kpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]       cfg_data
);
  import kpc_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LANE_LIMIT-1:0]  lanes_t;

  // configuration
  logic [CFG_W-1:0] short_time, long_time, long_long_time;
  logic [CFG_W-1:0] click_gap_time, click_hold_time;

  // input register
  logic   in_valid;
  lanes_t in_scan;

  // key state
  count_t tick_count      [NUM_KEYS];
  count_t tick_count_next [NUM_KEYS];
  lanes_t held_flags, short_flags, long_flags, very_long_flags;
  lanes_t single_flags, double_flags, triple_flags;
  lanes_t first_pending, second_pending;
  lanes_t held_next, short_next, long_next, very_long_next;
  lanes_t single_next, double_next, triple_next;
  lanes_t first_next, second_next;
  logic   changed_next;

  logic advance;

  assign advance    = in_valid && (!result_valid || !result_stall);
  assign scan_stall = in_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_time      <= SHORT_TIME_RST;
      long_time       <= LONG_TIME_RST;
      long_long_time  <= LONG_LONG_TIME_RST;
      click_gap_time  <= CLICK_GAP_TIME_RST;
      click_hold_time <= CLICK_HOLD_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_TIME:      short_time      <= cfg_data;
        REG_LONG_TIME:       long_time       <= cfg_data;
        REG_LONG_LONG_TIME:  long_long_time  <= cfg_data;
        REG_CLICK_GAP_TIME:  click_gap_time  <= cfg_data;
        REG_CLICK_HOLD_TIME: click_hold_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan_valid && !scan_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && !scan_stall) begin
      in_scan <= scan_bits;
    end
  end

  // lane update; lanes at or above NUM_KEYS keep their zero state
  always_comb begin
    count_t           cnt;
    count_t           inc;
    logic [CFG_W-1:0] cnt_ext;
    logic [CFG_W-1:0] inc_ext;
    logic             clicks;
    held_next      = held_flags;
    short_next     = short_flags;
    long_next      = long_flags;
    very_long_next = very_long_flags;
    single_next    = single_flags;
    double_next    = double_flags;
    triple_next    = triple_flags;
    first_next     = first_pending;
    second_next    = second_pending;
    changed_next   = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      tick_count_next[i] = tick_count[i];
      clicks  = single_flags[i] | double_flags[i] | triple_flags[i];
      cnt     = (in_scan[i] && !held_flags[i]) ? '0 : tick_count[i];
      inc     = cnt + 1'b1;
      cnt_ext = CFG_W'(cnt);
      inc_ext = CFG_W'(inc);
      if (in_scan[i]) begin
        if (!held_flags[i]) begin
          held_next[i] = 1'b1;
          changed_next = 1'b1;
        end
        tick_count_next[i] = cnt;
        if (cnt_ext <= long_long_time) begin
          tick_count_next[i] = inc;
          if (inc_ext >= long_long_time) begin
            very_long_next[i] = 1'b1;
            if (!very_long_flags[i]) changed_next = 1'b1;
          end else if (inc_ext >= long_time) begin
            long_next[i] = 1'b1;
            if (!long_flags[i]) changed_next = 1'b1;
          end else if (inc_ext >= short_time) begin
            short_next[i] = 1'b1;
            if (!short_flags[i]) changed_next = 1'b1;
          end
        end
      end else if (held_flags[i]) begin
        if (!clicks) begin
          if (cnt_ext < short_time) begin
            // tap: advance the click chain
            if (first_pending[i]) begin
              if (second_pending[i]) begin
                triple_next[i] = 1'b1;
                first_next[i]  = 1'b0;
                second_next[i] = 1'b0;
              end else begin
                second_next[i] = 1'b1;
              end
            end else begin
              first_next[i] = 1'b1;
            end
          end else begin
            first_next[i]  = 1'b0;
            second_next[i] = 1'b0;
          end
        end
        held_next[i]       = 1'b0;
        short_next[i]      = 1'b0;
        long_next[i]       = 1'b0;
        very_long_next[i]  = 1'b0;
        tick_count_next[i] = '0;
        changed_next       = 1'b1;
      end else if (first_pending[i] || second_pending[i]) begin
        tick_count_next[i] = inc;
        if (inc_ext >= click_gap_time) begin
          tick_count_next[i] = '0;
          if (second_pending[i]) begin
            double_next[i] = 1'b1;
          end else begin
            single_next[i] = 1'b1;
          end
          first_next[i]  = 1'b0;
          second_next[i] = 1'b0;
          changed_next   = 1'b1;
        end
      end else if (clicks) begin
        tick_count_next[i] = inc;
        if (inc_ext >= click_hold_time) begin
          tick_count_next[i] = '0;
          single_next[i]     = 1'b0;
          double_next[i]     = 1'b0;
          triple_next[i]     = 1'b0;
          changed_next       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        tick_count[i] <= '0;
      end
      held_flags      <= '0;
      short_flags     <= '0;
      long_flags      <= '0;
      very_long_flags <= '0;
      single_flags    <= '0;
      double_flags    <= '0;
      triple_flags    <= '0;
      first_pending   <= '0;
      second_pending  <= '0;
    end else if (advance) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        tick_count[i] <= tick_count_next[i];
      end
      held_flags      <= held_next;
      short_flags     <= short_next;
      long_flags      <= long_next;
      very_long_flags <= very_long_next;
      single_flags    <= single_next;
      double_flags    <= double_next;
      triple_flags    <= triple_next;
      first_pending   <= first_next;
      second_pending  <= second_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_mask         <= held_next;
      short_mask        <= short_next;
      long_mask         <= long_next;
      very_long_mask    <= very_long_next;
      single_click_mask <= single_next;
      double_click_mask <= double_next;
      triple_click_mask <= triple_next;
      changed           <= changed_next;
    end
  end

endmodule

### dv/tb_key_press_click_decoder.sv
// Testbench for key_press_click_decoder: scan word stimulus, lane-level mask predictor, checker.
module tb_key_press_click_decoder;
  import kpc_pkg::*;

  typedef struct {
    logic [LANE_LIMIT-1:0] held_m;
    logic [LANE_LIMIT-1:0] short_m;
    logic [LANE_LIMIT-1:0] long_m;
    logic [LANE_LIMIT-1:0] vlong_m;
    logic [LANE_LIMIT-1:0] single_m;
    logic [LANE_LIMIT-1:0] double_m;
    logic [LANE_LIMIT-1:0] triple_m;
    logic                  chg;
  } key_tick_t;

  localparam logic [LANE_LIMIT-1:0] DIRECTED_WORDS [22] = '{
    32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000,
    // taps: low 16 keys three times, next 8 twice, top 8 once
    32'hFFFF_FFFF, 32'h0000_0000,
    32'h00FF_FFFF, 32'h0000_0000,
    32'h0000_FFFF, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   scan_valid = 1'b0;
  logic                   scan_stall;
  logic [LANE_LIMIT-1:0]  scan_bits = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [LANE_LIMIT-1:0]  held_mask;
  logic [LANE_LIMIT-1:0]  short_mask;
  logic [LANE_LIMIT-1:0]  long_mask;
  logic [LANE_LIMIT-1:0]  very_long_mask;
  logic [LANE_LIMIT-1:0]  single_click_mask;
  logic [LANE_LIMIT-1:0]  double_click_mask;
  logic [LANE_LIMIT-1:0]  triple_click_mask;
  logic                   changed;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  key_press_click_decoder u_top (
    .clk               (clk),
    .rst               (rst),
    .scan_valid        (scan_valid),
    .scan_stall        (scan_stall),
    .scan_bits         (scan_bits),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .held_mask         (held_mask),
    .short_mask        (short_mask),
    .long_mask         (long_mask),
    .very_long_mask    (very_long_mask),
    .single_click_mask (single_click_mask),
    .double_click_mask (double_click_mask),
    .triple_click_mask (triple_click_mask),
    .changed           (changed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predictor copy of thresholds and lane state
  logic [CFG_W-1:0]           t_short, t_long, t_vlong, t_gap, t_hold;
  logic [COUNT_WIDTH_DEF-1:0] lane_cnt [LANE_LIMIT];
  logic [LANE_LIMIT-1:0]      st_held, st_short, st_long, st_vlong;
  logic [LANE_LIMIT-1:0]      st_single, st_double, st_triple, st_first, st_second;

  // stimulus generator lane state
  logic                       gen_down [LANE_LIMIT];
  int unsigned                gen_left [LANE_LIMIT];

  logic [LANE_LIMIT-1:0] scan_q [$];
  key_tick_t             pending_masks_q [$];
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    mismatches = 0;
  int                    words_checked = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      REG_SHORT_TIME:      t_short = val;
      REG_LONG_TIME:       t_long  = val;
      REG_LONG_LONG_TIME:  t_vlong = val;
      REG_CLICK_GAP_TIME:  t_gap   = val;
      REG_CLICK_HOLD_TIME: t_hold  = val;
      default: ;
    endcase
  endfunction

  function automatic key_tick_t decode_tick(input logic [LANE_LIMIT-1:0] scan);
    key_tick_t r;
    logic      hit;
    hit = 1'b0;
    for (int k = 0; k < LANE_LIMIT; k++) begin
      if (scan[k]) begin
        if (!st_held[k]) begin
          st_held[k] = 1'b1;
          lane_cnt[k] = '0;
          hit = 1'b1;
        end
        // counter stops one above the very-long threshold
        if (lane_cnt[k] <= t_vlong) begin
          lane_cnt[k] = lane_cnt[k] + 1'b1;
          if (lane_cnt[k] >= t_vlong) begin
            hit |= !st_vlong[k];
            st_vlong[k] = 1'b1;
          end else if (lane_cnt[k] >= t_long) begin
            hit |= !st_long[k];
            st_long[k] = 1'b1;
          end else if (lane_cnt[k] >= t_short) begin
            hit |= !st_short[k];
            st_short[k] = 1'b1;
          end
        end
      end else if (st_held[k]) begin
        if (!(st_single[k] | st_double[k] | st_triple[k])) begin
          if (lane_cnt[k] < t_short) begin
            if (!st_first[k]) begin
              st_first[k] = 1'b1;
            end else if (!st_second[k]) begin
              st_second[k] = 1'b1;
            end else begin
              st_triple[k] = 1'b1;
              st_first[k]  = 1'b0;
              st_second[k] = 1'b0;
            end
          end else begin
            st_first[k]  = 1'b0;
            st_second[k] = 1'b0;
          end
        end
        st_held[k]  = 1'b0;
        st_short[k] = 1'b0;
        st_long[k]  = 1'b0;
        st_vlong[k] = 1'b0;
        lane_cnt[k] = '0;
        hit = 1'b1;
      end else if (st_first[k] | st_second[k]) begin
        lane_cnt[k] = lane_cnt[k] + 1'b1;
        if (lane_cnt[k] >= t_gap) begin
          lane_cnt[k] = '0;
          if (st_second[k]) st_double[k] = 1'b1;
          else st_single[k] = 1'b1;
          st_first[k]  = 1'b0;
          st_second[k] = 1'b0;
          hit = 1'b1;
        end
      end else if (st_single[k] | st_double[k] | st_triple[k]) begin
        lane_cnt[k] = lane_cnt[k] + 1'b1;
        if (lane_cnt[k] >= t_hold) begin
          lane_cnt[k]  = '0;
          st_single[k] = 1'b0;
          st_double[k] = 1'b0;
          st_triple[k] = 1'b0;
          hit = 1'b1;
        end
      end
    end
    r.held_m   = st_held;
    r.short_m  = st_short;
    r.long_m   = st_long;
    r.vlong_m  = st_vlong;
    r.single_m = st_single;
    r.double_m = st_double;
    r.triple_m = st_triple;
    r.chg      = hit;
    return r;
  endfunction

  // segment length up to a threshold, capped so huge thresholds stay cheap
  function automatic int unsigned seg_len(input int unsigned th);
    int unsigned top;
    top = (th > 40) ? 40 : ((th < 2) ? 2 : th);
    return $urandom_range(1, top);
  endfunction

  // mostly well-formed press/release trains per key, with some noise words
  function automatic logic [LANE_LIMIT-1:0] next_scan_word();
    logic [LANE_LIMIT-1:0] w;
    int unsigned           pick;
    for (int k = 0; k < LANE_LIMIT; k++) begin
      if (gen_left[k] == 0) begin
        gen_down[k] = !gen_down[k];
        pick = $urandom_range(0, 9);
        if (gen_down[k]) begin
          if (pick < 6) gen_left[k] = seg_len(t_short);
          else if (pick < 8) gen_left[k] = seg_len(int'(t_long) + 2);
          else gen_left[k] = seg_len(int'(t_vlong) + 3);
        end else begin
          if (pick < 6) gen_left[k] = seg_len(t_gap);
          else gen_left[k] = seg_len(int'(t_gap) + int'(t_hold) + 3);
        end
      end
      w[k] = gen_down[k];
      gen_left[k]--;
    end
    if ($urandom_range(0, 99) < 12) w = $urandom();
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH at result word %0d: %s", words_checked, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [LANE_LIMIT-1:0] got,
                             input logic [LANE_LIMIT-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
  endtask

  task automatic load_timing(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] l,
                             input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] g,
                             input logic [CFG_W-1:0] h);
    write_reg(REG_SHORT_TIME, s);
    write_reg(REG_LONG_TIME, l);
    write_reg(REG_LONG_LONG_TIME, v);
    write_reg(REG_CLICK_GAP_TIME, g);
    write_reg(REG_CLICK_HOLD_TIME, h);
    // unmapped indexes must be ignored
    for (int i = int'(REG_CLICK_HOLD_TIME) + 1; i < (1 << CFG_INDEX_W); i++)
      write_reg(CFG_INDEX_W'(i), CFG_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (scan_q.size() != 0 || scan_valid || pending_masks_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] l,
                           input logic [CFG_W-1:0] v, input logic [CFG_W-1:0] g,
                           input logic [CFG_W-1:0] h, input int send_pct,
                           input int stall_p, input int n_words);
    wait_idle();
    repeat (4) @(posedge clk);
    load_timing(s, l, v, g, h);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    for (int i = 0; i < n_words; i++) begin
      // sender holds off mid-phase until every result is back
      if (i == n_words / 2) wait_idle();
      scan_q.push_back(next_scan_word());
    end
  endtask

  // scan word driver
  always @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else begin
      if (scan_valid && !scan_stall) pending_masks_q.push_back(decode_tick(scan_bits));
      if (!scan_valid || !scan_stall) begin
        if (scan_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          scan_valid <= 1'b1;
          scan_bits  <= scan_q.pop_front();
        end else begin
          scan_valid <= 1'b0;
          scan_bits  <= $urandom();
        end
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result word monitor
  always @(posedge clk) begin : mask_monitor
    key_tick_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_masks_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_masks_q.pop_front();
        check_field("held_mask", held_mask, want.held_m);
        check_field("short_mask", short_mask, want.short_m);
        check_field("long_mask", long_mask, want.long_m);
        check_field("very_long_mask", very_long_mask, want.vlong_m);
        check_field("single_click_mask", single_click_mask, want.single_m);
        check_field("double_click_mask", double_click_mask, want.double_m);
        check_field("triple_click_mask", triple_click_mask, want.triple_m);
        check_field("changed", LANE_LIMIT'(changed), LANE_LIMIT'(want.chg));
      end
      words_checked++;
    end
  end

  initial begin
    t_short = SHORT_TIME_RST;
    t_long  = LONG_TIME_RST;
    t_vlong = LONG_LONG_TIME_RST;
    t_gap   = CLICK_GAP_TIME_RST;
    t_hold  = CLICK_HOLD_TIME_RST;
    st_held = '0; st_short = '0; st_long = '0; st_vlong = '0;
    st_single = '0; st_double = '0; st_triple = '0; st_first = '0; st_second = '0;
    for (int k = 0; k < LANE_LIMIT; k++) begin
      lane_cnt[k] = '0;
      gen_down[k] = 1'b0;
      gen_left[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: full hold through all marks, then triple/double/single taps
    load_timing(16'd3, 16'd5, 16'd7, 16'd4, 16'd2);
    @(negedge clk);
    foreach (DIRECTED_WORDS[i]) scan_q.push_back(DIRECTED_WORDS[i]);

    run_phase(16'd3, 16'd5, 16'd7, 16'd4, 16'd2, 0, 0, 160);
    run_phase(16'd2, 16'd6, 16'd12, 16'd6, 16'd4, 65, 0, 160);
    // zero thresholds: everything fires on the first tick
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0, 65, 110);
    // unordered thresholds
    run_phase(16'd4, 16'd2, 16'd6, 16'd3, 16'd5, 20, 20, 120);
    // equal thresholds
    run_phase(16'd4, 16'd4, 16'd4, 16'd1, 16'd1, 0, 65, 120);
    run_phase(16'd65534, 16'd65534, 16'd65534, 16'd65534, 16'd65534, 20, 20, 60);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
